[sv/scpmc_pkg.sv]
// scpmc_pkg: shared types and constants of the serial commanded pwm motor controller
// no dependencies; used by the command decoder, the top level and the port checker
`default_nettype none
package scpmc_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_PULSE = 2'd2;

  localparam logic [7:0] CMD_ESC    = 8'h1B;
  localparam logic [7:0] CMD_DUTY0  = 8'h34;
  localparam logic [7:0] CMD_DUTY1  = 8'h35;
  localparam logic [7:0] CMD_DUTY2  = 8'h36;
  localparam logic [7:0] CMD_DUTY3  = 8'h37;
  localparam logic [7:0] CMD_DUTY4  = 8'h38;
  localparam logic [7:0] CMD_DUTY5  = 8'h39;
  localparam logic [7:0] CMD_TOP    = 8'h2A;
  localparam logic [7:0] CMD_BOTTOM = 8'h23;
  localparam logic [7:0] CMD_ARM    = 8'h30;

  localparam logic [7:0] DUTY_ZERO  = 8'h00;
  localparam logic [7:0] DUTY_20    = 8'h33;
  localparam logic [7:0] DUTY_40    = 8'h66;
  localparam logic [7:0] DUTY_60    = 8'h99;
  localparam logic [7:0] DUTY_80    = 8'hCC;
  localparam logic [7:0] DUTY_FULL  = 8'hFF;

  localparam logic [7:0] LIMIT_RESET = 8'h0A;

  typedef struct packed {
    logic       esc;
    logic       set_duty;
    logic [7:0] duty;
    logic       toggle_top;
    logic       toggle_bottom;
    logic       arm;
  } cmd_t;

endpackage
`default_nettype wire

[sv/serial_commanded_pwm_motor_controller_top.sv]
// latency: a result is valid in the cycle after its input transaction is accepted
// throughput: one transaction per cycle; the controller state feeds a single
// result register, and input is accepted whenever that register is empty or being taken
// reset: synchronous, active high; clears duty, slider, count, arming, enable and the
// result register, sets both directions forward and the revolution limit to 10
// depends on scpmc_pkg and scpmc_cmd_decode
`default_nettype none
module serial_commanded_pwm_motor_controller_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] command_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            motor_enable,
  output logic            top_forward,
  output logic            bottom_forward,
  output logic            send_plus
);

  logic [7:0] revolution_limit;
  logic [7:0] duty_level;
  logic [7:0] pwm_slider;
  logic [7:0] revolution_count;
  logic       counting_armed;
  logic       top_dir;
  logic       bottom_dir;
  logic       enable_reg;

  logic [7:0] duty_level_next;
  logic [7:0] pwm_slider_next;
  logic [7:0] revolution_count_next;
  logic       counting_armed_next;
  logic       top_dir_next;
  logic       bottom_dir_next;
  logic       enable_reg_next;
  logic       send_plus_next;

  scpmc_pkg::cmd_t cmd;
  logic            accept;

  scpmc_cmd_decode u_decode (
    .command_byte (command_byte),
    .cmd          (cmd)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    duty_level_next       = duty_level;
    pwm_slider_next       = pwm_slider;
    revolution_count_next = revolution_count;
    counting_armed_next   = counting_armed;
    top_dir_next          = top_dir;
    bottom_dir_next       = bottom_dir;
    enable_reg_next       = enable_reg;
    send_plus_next        = 1'b0;
    case (kind)
      scpmc_pkg::KIND_TICK: begin
        if (duty_level == scpmc_pkg::DUTY_ZERO) begin
          enable_reg_next = 1'b0;
        end else if (duty_level == scpmc_pkg::DUTY_FULL) begin
          enable_reg_next = 1'b1;
        end else begin
          enable_reg_next = pwm_slider < duty_level;
          pwm_slider_next = pwm_slider + 8'd1;
        end
      end
      scpmc_pkg::KIND_CMD: begin
        if (cmd.esc) begin
          counting_armed_next   = 1'b0;
          revolution_count_next = '0;
          duty_level_next       = scpmc_pkg::DUTY_ZERO;
          top_dir_next          = 1'b1;
          bottom_dir_next       = 1'b1;
        end
        if (cmd.set_duty) begin
          duty_level_next = cmd.duty;
        end
        if (cmd.toggle_top) begin
          top_dir_next = !top_dir;
        end
        if (cmd.toggle_bottom) begin
          bottom_dir_next = !bottom_dir;
        end
        if (cmd.arm) begin
          counting_armed_next = 1'b1;
        end
      end
      scpmc_pkg::KIND_PULSE: begin
        if (counting_armed) begin
          if (revolution_count < revolution_limit) begin
            revolution_count_next = revolution_count + 8'd1;
            send_plus_next        = 1'b1;
          end else begin
            revolution_count_next = '0;
            duty_level_next       = scpmc_pkg::DUTY_ZERO;
            counting_armed_next   = 1'b0;
          end
        end
      end
      default: begin
        send_plus_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      revolution_limit <= scpmc_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      revolution_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_level       <= scpmc_pkg::DUTY_ZERO;
      pwm_slider       <= '0;
      revolution_count <= '0;
      counting_armed   <= 1'b0;
      top_dir          <= 1'b1;
      bottom_dir       <= 1'b1;
      enable_reg       <= 1'b0;
    end else if (accept) begin
      duty_level       <= duty_level_next;
      pwm_slider       <= pwm_slider_next;
      revolution_count <= revolution_count_next;
      counting_armed   <= counting_armed_next;
      top_dir          <= top_dir_next;
      bottom_dir       <= bottom_dir_next;
      enable_reg       <= enable_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      motor_enable   <= enable_reg_next;
      top_forward    <= top_dir_next;
      bottom_forward <= bottom_dir_next;
      send_plus      <= send_plus_next;
    end
  end

endmodule
`default_nettype wire

[sv/scpmc_cmd_decode.sv]
// scpmc_cmd_decode: turns a received command byte into a set of control strobes
// depends on scpmc_pkg
`default_nettype none
module scpmc_cmd_decode (
  input  wire logic [7:0]     command_byte,
  output scpmc_pkg::cmd_t     cmd
);

  always_comb begin
    cmd = '0;
    unique case (command_byte)
      scpmc_pkg::CMD_ESC: begin
        cmd.esc = 1'b1;
      end
      scpmc_pkg::CMD_DUTY0: begin
        cmd.set_duty = 1'b1;
        cmd.duty     = scpmc_pkg::DUTY_ZERO;
      end
      scpmc_pkg::CMD_DUTY1: begin
        cmd.set_duty = 1'b1;
        cmd.duty     = scpmc_pkg::DUTY_20;
      end
      scpmc_pkg::CMD_DUTY2: begin
        cmd.set_duty = 1'b1;
        cmd.duty     = scpmc_pkg::DUTY_40;
      end
      scpmc_pkg::CMD_DUTY3: begin
        cmd.set_duty = 1'b1;
        cmd.duty     = scpmc_pkg::DUTY_60;
      end
      scpmc_pkg::CMD_DUTY4: begin
        cmd.set_duty = 1'b1;
        cmd.duty     = scpmc_pkg::DUTY_80;
      end
      scpmc_pkg::CMD_DUTY5: begin
        cmd.set_duty = 1'b1;
        cmd.duty     = scpmc_pkg::DUTY_FULL;
      end
      scpmc_pkg::CMD_TOP: begin
        cmd.toggle_top = 1'b1;
      end
      scpmc_pkg::CMD_BOTTOM: begin
        cmd.toggle_bottom = 1'b1;
      end
      scpmc_pkg::CMD_ARM: begin
        cmd.arm = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/scpmc_port_checker.sv]
// scpmc_port_checker: concurrent assertions on the top level ports over time
// depends on scpmc_pkg; bound to serial_commanded_pwm_motor_controller_top
`default_nettype none
module scpmc_port_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] kind,
  input wire logic [7:0] command_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       motor_enable,
  input wire logic       top_forward,
  input wire logic       bottom_forward,
  input wire logic       send_plus
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motor_enable) && $stable(top_forward)
      && $stable(bottom_forward) && $stable(send_plus))
    else $error("stalled result changed");

  a_no_input_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction gave no result");

  a_esc_resets_dirs: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == scpmc_pkg::KIND_CMD && command_byte == scpmc_pkg::CMD_ESC
      |=> top_forward && bottom_forward && !send_plus)
    else $error("escape did not restore directions");

  a_plus_only_on_pulse: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind != scpmc_pkg::KIND_PULSE |=> !send_plus)
    else $error("plus requested without a pulse");

endmodule

bind serial_commanded_pwm_motor_controller_top scpmc_port_checker u_port_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .kind           (kind),
  .command_byte   (command_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .motor_enable   (motor_enable),
  .top_forward    (top_forward),
  .bottom_forward (bottom_forward),
  .send_plus      (send_plus)
);
`default_nettype wire

[bench/scpmc_checker.sv]
`timescale 1ns / 100ps
// scpmc_checker: watches the ports of the motor controller, predicts each result
// from the accepted input transactions and compares them in order
// depends on scpmc_pkg; instantiated by tb beside the controller
module scpmc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] command_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       motor_enable,
  input  logic       top_forward,
  input  logic       bottom_forward,
  input  logic       send_plus,
  output int         fail_count,
  output int         pending,
  output int         plus_seen,
  output int         stops_seen
);

  typedef struct packed {
    logic enable;
    logic top_fwd;
    logic bottom_fwd;
    logic plus;
  } motor_out_t;

  motor_out_t expected_outputs[$];

  logic [7:0] duty;
  logic [7:0] slider;
  logic [7:0] rev_count;
  logic [7:0] rev_limit;
  logic       armed;
  logic       top_dir;
  logic       bottom_dir;
  logic       enable;

  int mismatches = 0;
  int plus_count = 0;
  int stop_count = 0;

  assign fail_count = mismatches;
  assign plus_seen  = plus_count;
  assign stops_seen = stop_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0b expected %0b", name, got, want));
    end
  endtask

  task automatic step_controller(input logic [1:0] k, input logic [7:0] b,
                                 output motor_out_t r);
    r.plus = 1'b0;
    case (k)
      scpmc_pkg::KIND_TICK: begin
        if (duty == scpmc_pkg::DUTY_ZERO) begin
          enable = 1'b0;
        end else if (duty == scpmc_pkg::DUTY_FULL) begin
          enable = 1'b1;
        end else begin
          enable = (slider < duty);
          slider = slider + 8'd1;
        end
      end
      scpmc_pkg::KIND_CMD: begin
        case (b)
          scpmc_pkg::CMD_ESC: begin
            armed      = 1'b0;
            rev_count  = 8'd0;
            duty       = scpmc_pkg::DUTY_ZERO;
            top_dir    = 1'b1;
            bottom_dir = 1'b1;
          end
          scpmc_pkg::CMD_DUTY0:  duty = scpmc_pkg::DUTY_ZERO;
          scpmc_pkg::CMD_DUTY1:  duty = scpmc_pkg::DUTY_20;
          scpmc_pkg::CMD_DUTY2:  duty = scpmc_pkg::DUTY_40;
          scpmc_pkg::CMD_DUTY3:  duty = scpmc_pkg::DUTY_60;
          scpmc_pkg::CMD_DUTY4:  duty = scpmc_pkg::DUTY_80;
          scpmc_pkg::CMD_DUTY5:  duty = scpmc_pkg::DUTY_FULL;
          scpmc_pkg::CMD_TOP:    top_dir = ~top_dir;
          scpmc_pkg::CMD_BOTTOM: bottom_dir = ~bottom_dir;
          scpmc_pkg::CMD_ARM:    armed = 1'b1;
          default: ;
        endcase
      end
      scpmc_pkg::KIND_PULSE: begin
        if (armed) begin
          if (rev_count < rev_limit) begin
            rev_count = rev_count + 8'd1;
            r.plus = 1'b1;
            plus_count++;
          end else begin
            // limit reached: stop the motors, enable only falls at the next tick
            rev_count = 8'd0;
            duty = scpmc_pkg::DUTY_ZERO;
            armed = 1'b0;
            stop_count++;
          end
        end
      end
      default: ;
    endcase
    r.enable     = enable;
    r.top_fwd    = top_dir;
    r.bottom_fwd = bottom_dir;
  endtask

  always @(posedge clk) begin : watch
    motor_out_t want;
    motor_out_t got;
    if (rst) begin
      duty       = scpmc_pkg::DUTY_ZERO;
      slider     = 8'd0;
      rev_count  = 8'd0;
      rev_limit  = scpmc_pkg::LIMIT_RESET;
      armed      = 1'b0;
      top_dir    = 1'b1;
      bottom_dir = 1'b1;
      enable     = 1'b0;
      expected_outputs.delete();
    end else begin
      if (cfg_wr_en) begin
        rev_limit = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        got = {motor_enable, top_forward, bottom_forward, send_plus};
        if (expected_outputs.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_outputs.pop_front();
          check_field("motor_enable", got.enable, want.enable);
          check_field("top_forward", got.top_fwd, want.top_fwd);
          check_field("bottom_forward", got.bottom_fwd, want.bottom_fwd);
          check_field("send_plus", got.plus, want.plus);
        end
      end
      if (in_valid && in_ready) begin
        step_controller(kind, command_byte, want);
        expected_outputs.push_back(want);
      end
    end
    pending <= expected_outputs.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// tb: stimulus, handshake pacing and verdict for the serial commanded pwm motor controller
// depends on scpmc_pkg, serial_commanded_pwm_motor_controller_top and scpmc_checker
module tb;

  localparam logic [1:0] KIND_NONE = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = scpmc_pkg::KIND_TICK;
  logic [7:0] command_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       motor_enable;
  logic       top_forward;
  logic       bottom_forward;
  logic       send_plus;

  int fail_count;
  int pending;
  int plus_seen;
  int stops_seen;
  int items_sent = 0;
  int results_taken = 0;
  int limit_writes = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  serial_commanded_pwm_motor_controller_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .command_byte   (command_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_enable   (motor_enable),
    .top_forward    (top_forward),
    .bottom_forward (bottom_forward),
    .send_plus      (send_plus)
  );

  scpmc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .command_byte   (command_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_enable   (motor_enable),
    .top_forward    (top_forward),
    .bottom_forward (bottom_forward),
    .send_plus      (send_plus),
    .fail_count     (fail_count),
    .pending        (pending),
    .plus_seen      (plus_seen),
    .stops_seen     (stops_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d transactions sent, %0d results outstanding", items_sent, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] command_at(input int idx);
    case (idx)
      0: return scpmc_pkg::CMD_ESC;
      1: return scpmc_pkg::CMD_DUTY0;
      2: return scpmc_pkg::CMD_DUTY1;
      3: return scpmc_pkg::CMD_DUTY2;
      4: return scpmc_pkg::CMD_DUTY3;
      5: return scpmc_pkg::CMD_DUTY4;
      6: return scpmc_pkg::CMD_DUTY5;
      7: return scpmc_pkg::CMD_TOP;
      8: return scpmc_pkg::CMD_BOTTOM;
      default: return scpmc_pkg::CMD_ARM;
    endcase
  endfunction

  task automatic send(input logic [1:0] k, input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    command_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random(input int pulse_pct, input bit allow_esc);
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (r < pulse_pct) begin
      send(scpmc_pkg::KIND_PULSE, b);
    end else if (r < pulse_pct + 3) begin
      send(KIND_NONE, b);
    end else if (r % 2 == 0) begin
      send(scpmc_pkg::KIND_TICK, b);
    end else begin
      if ($urandom_range(0, 6) != 0) begin
        b = command_at($urandom_range(allow_esc ? 0 : 1, 9));
      end
      send(scpmc_pkg::KIND_CMD, b);
    end
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] lim);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_writes++;
  endtask

  // result side, with two long hold-offs to back the controller up
  initial begin : receiver
    int w;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      w = draw_wait(take_burst);
      if (results_taken == 150 || results_taken == 1000) w = 120;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset limit, each command and kind
    send(scpmc_pkg::KIND_TICK, 8'h00);
    send(scpmc_pkg::KIND_PULSE, 8'hFF);
    send(KIND_NONE, 8'hA5);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_DUTY1);
    send(scpmc_pkg::KIND_TICK, 8'h5A);
    send(scpmc_pkg::KIND_TICK, 8'h00);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_DUTY2);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_DUTY3);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_DUTY4);
    send(scpmc_pkg::KIND_TICK, 8'hFF);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_DUTY5);
    send(scpmc_pkg::KIND_TICK, 8'h00);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_TOP);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_BOTTOM);
    send(scpmc_pkg::KIND_CMD, 8'h00);
    send(scpmc_pkg::KIND_CMD, 8'hFF);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_ARM);
    send(scpmc_pkg::KIND_PULSE, 8'h00);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_ESC);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_DUTY0);
    send(scpmc_pkg::KIND_TICK, 8'h00);

    // zero limit stops on the first armed pulse
    set_limit(8'd0);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_ARM);
    send(scpmc_pkg::KIND_PULSE, 8'h00);
    send(scpmc_pkg::KIND_PULSE, 8'h00);

    // limit one, enable falls on the tick after the stop
    set_limit(8'd1);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_DUTY2);
    send(scpmc_pkg::KIND_TICK, 8'h00);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_ARM);
    send(scpmc_pkg::KIND_PULSE, 8'h00);
    send(scpmc_pkg::KIND_PULSE, 8'h00);
    send(scpmc_pkg::KIND_TICK, 8'h00);

    set_limit(8'd255);
    send(scpmc_pkg::KIND_CMD, scpmc_pkg::CMD_ARM);
    repeat (450) send_random(80, 1'b0);
    set_limit(8'd2);
    repeat (220) send_random(30, 1'b1);
    set_limit(8'd0);
    repeat (200) send_random(30, 1'b1);
    set_limit(scpmc_pkg::LIMIT_RESET);
    repeat (280) send_random(35, 1'b1);
    set_limit(8'($urandom_range(3, 254)));
    repeat (240) send_random(40, 1'b1);
    set_limit(8'd1);
    repeat (200) send_random(30, 1'b1);
    set_limit(8'($urandom_range(0, 255)));
    repeat (240) send_random(35, 1'b1);

    settle();
    $display("covered %0d transactions over %0d limit settings, 0 and 255 among them",
             items_sent, limit_writes + 1);
    $display("%0d results taken, %0d counted revolutions, %0d motor stops",
             results_taken, plus_seen, stops_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
